/* rtl/alpnp_pkg.sv */
// ----------------------------------------------------------------------------
// alpnp_pkg
// Shared types and constants for the ALPN extension body parser.
// ----------------------------------------------------------------------------
package alpnp_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned LIST_LEN_W = 16;
   localparam int unsigned BYTE_CNT_W = 17;
   localparam int unsigned NAME_CNT_W = 15;
   localparam int unsigned STATUS_W   = 3;

   // parse phase: header high byte, header low byte, name length, name text
   typedef enum logic [1:0] {
      PH_HDR_HI = 2'd0,
      PH_HDR_LO = 2'd1,
      PH_LEN    = 2'd2,
      PH_TEXT   = 2'd3
   } phase_type;

   // frame status, reported on the closing word
   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 3'd0,
      ST_SHORT_HDR    = 3'd1,
      ST_LEN_MISMATCH = 3'd2,
      ST_EMPTY_NAME   = 3'd3,
      ST_TRUNCATED    = 3'd4,
      ST_SERVER_COUNT = 3'd5
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } req_word_type;

   typedef struct packed {
      logic [BYTE_W-1:0]     byte_out;
      logic                  in_name;
      logic                  name_first;
      logic                  name_last;
      logic [NAME_CNT_W-1:0] name_number;
      logic                  frame_end;
      status_type            status;
      logic [NAME_CNT_W-1:0] name_total;
   } rsp_word_type;

endpackage

/* rtl/alpnp_ifs.sv */
// ----------------------------------------------------------------------------
// alpnp_ifs
// Valid/ready channels of the ALPN parser: input bytes, results, register.
// ----------------------------------------------------------------------------

// input byte channel
interface alpnp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// result channel
interface alpnp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  byte_out;
   logic        in_name;
   logic        name_first;
   logic        name_last;
   logic [14:0] name_number;
   logic        frame_end;
   logic [2:0]  status;
   logic [14:0] name_total;

   modport source (output valid, output byte_out, output in_name, output name_first,
                   output name_last, output name_number, output frame_end,
                   output status, output name_total, input ready);
   modport sink   (input valid, input byte_out, input in_name, input name_first,
                   input name_last, input name_number, input frame_end,
                   input status, input name_total, output ready);
endinterface

// register write channel
interface alpnp_csr_if;
   logic valid;
   logic ready;
   logic server_side;

   modport source (output valid, output server_side, input ready);
   modport sink   (input valid, input server_side, output ready);
endinterface

/* rtl/alpn_extension_parser.sv */
// ----------------------------------------------------------------------------
// alpn_extension_parser
// Byte-serial parser for the body of a TLS ALPN extension.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch  : one extension byte per word, last_byte set on the final byte.
//   rsp_ch  : one result word per input byte: the byte echoed, name flags,
//             name number; on the closing word frame_end, status, name_total.
//   csr_ch  : server_side bit; always ready, write it only while idle.
// Path: an accepted byte is held in the input register, decoded, and loaded
//   into the result register, which drives rsp_ch.
// Throughput: one byte per cycle while rsp_ch is ready, set by the single
//   decode stage between the input register and the result register.
// Reset clears the parse state to the header phase, empties both registers
//   and sets server_side to 0. After each closing byte the parse state
//   returns to the header phase on its own.
// Stall: when rsp_ch is not ready the result register holds, one more byte
//   waits in the input register, then req_ch.ready drops.
// ----------------------------------------------------------------------------
module alpn_extension_parser (
   input  logic         clock,
   input  logic         reset,
   alpnp_req_if.sink    req_ch,
   alpnp_rsp_if.source  rsp_ch,
   alpnp_csr_if.sink    csr_ch
);

   logic                     word_valid;
   logic                     can_load;
   logic                     advance;
   logic                     server_side_ff;
   alpnp_pkg::req_word_type  word;
   alpnp_pkg::rsp_word_type  result;

   // register port
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         server_side_ff <= 1'b0;
      end else if (csr_ch.valid) begin
         server_side_ff <= csr_ch.server_side;
      end
   end

   // word moves from input register to result register
   assign advance = word_valid && can_load;

   alpnp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .advance    (advance),
      .word_valid (word_valid),
      .word       (word)
   );

   alpnp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .server_side (server_side_ff),
      .word        (word),
      .result      (result)
   );

   alpnp_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .rsp_ch   (rsp_ch),
      .load     (advance),
      .result   (result),
      .can_load (can_load)
   );

endmodule

/* rtl/alpnp_in_stage.sv */
// ----------------------------------------------------------------------------
// alpnp_in_stage
// Input register: holds one byte word until the parser consumes it.
// ----------------------------------------------------------------------------
module alpnp_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   alpnp_req_if.sink             req_ch,
   input  logic                  advance,
   output logic                  word_valid,
   output alpnp_pkg::req_word_type word
);

   logic                     valid_ff;
   logic                     valid_in;
   alpnp_pkg::req_word_type  word_ff;

   // take a new word when empty or when the held one moves on
   assign req_ch.ready = !valid_ff || advance;
   assign valid_in     = req_ch.valid ? 1'b1 : (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         word_ff.data_byte <= req_ch.data_byte;
         word_ff.last_byte <= req_ch.last_byte;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

/* rtl/alpnp_parser.sv */
// ----------------------------------------------------------------------------
// alpnp_parser
// Frame state and per-byte decode: length header, name lengths, name text.
// ----------------------------------------------------------------------------
module alpnp_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    server_side,
   input  alpnp_pkg::req_word_type word,
   output alpnp_pkg::rsp_word_type result
);

   alpnp_pkg::phase_type                  phase_ff, phase_in;
   logic [alpnp_pkg::LIST_LEN_W-1:0]      declared_length_ff, declared_length_in;
   logic [alpnp_pkg::BYTE_CNT_W-1:0]      bytes_after_header_ff, bytes_after_header_in;
   logic [alpnp_pkg::BYTE_W-1:0]          name_bytes_left_ff, name_bytes_left_in;
   logic [alpnp_pkg::NAME_CNT_W-1:0]      names_seen_ff, names_seen_in;
   logic                                  empty_name_seen_ff, empty_name_seen_in;
   logic                                  first_pending_ff, first_pending_in;

   logic [alpnp_pkg::BYTE_W-1:0]          left_dec;
   logic [alpnp_pkg::BYTE_CNT_W-1:0]      bytes_inc;
   logic                                  len_is_zero;

   assign left_dec    = name_bytes_left_ff - alpnp_pkg::BYTE_W'(1);
   assign len_is_zero = (word.data_byte == '0);
   // saturating byte count after the header
   assign bytes_inc   = (&bytes_after_header_ff) ? bytes_after_header_ff
                                                 : bytes_after_header_ff + 1'b1;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         alpnp_pkg::PH_HDR_HI: phase_in = alpnp_pkg::PH_HDR_LO;
         alpnp_pkg::PH_HDR_LO: phase_in = alpnp_pkg::PH_LEN;
         alpnp_pkg::PH_LEN: begin
            if (!len_is_zero) phase_in = alpnp_pkg::PH_TEXT;
         end
         alpnp_pkg::PH_TEXT: begin
            if (left_dec == '0) phase_in = alpnp_pkg::PH_LEN;
         end
      endcase
   end

   // counters and per-byte flags
   always_comb begin
      declared_length_in    = declared_length_ff;
      bytes_after_header_in = bytes_after_header_ff;
      name_bytes_left_in    = name_bytes_left_ff;
      names_seen_in         = names_seen_ff;
      empty_name_seen_in    = empty_name_seen_ff;
      first_pending_in      = first_pending_ff;

      result             = '0;
      result.byte_out    = word.data_byte;
      result.name_number = names_seen_ff;
      result.frame_end   = word.last_byte;
      result.status      = alpnp_pkg::ST_OK;

      unique case (phase_ff)
         alpnp_pkg::PH_HDR_HI: begin
            declared_length_in = {word.data_byte, 8'h00};
         end
         alpnp_pkg::PH_HDR_LO: begin
            declared_length_in = {declared_length_ff[15:8], word.data_byte};
         end
         alpnp_pkg::PH_LEN: begin
            bytes_after_header_in = bytes_inc;
            if (len_is_zero) begin
               empty_name_seen_in = 1'b1;
            end else begin
               name_bytes_left_in = word.data_byte;
               first_pending_in   = 1'b1;
            end
         end
         alpnp_pkg::PH_TEXT: begin
            bytes_after_header_in = bytes_inc;
            result.in_name        = 1'b1;
            result.name_first     = first_pending_ff;
            first_pending_in      = 1'b0;
            name_bytes_left_in    = left_dec;
            if (left_dec == '0) begin
               result.name_last = 1'b1;
               if (!(&names_seen_ff)) names_seen_in = names_seen_ff + 1'b1;
            end
         end
      endcase

      // frame status on the closing byte, first matching check wins
      if (word.last_byte) begin
         result.name_total = names_seen_in;
         priority if (phase_ff == alpnp_pkg::PH_HDR_HI)
            result.status = alpnp_pkg::ST_SHORT_HDR;
         else if ({1'b0, declared_length_in} != bytes_after_header_in)
            result.status = alpnp_pkg::ST_LEN_MISMATCH;
         else if (empty_name_seen_in)
            result.status = alpnp_pkg::ST_EMPTY_NAME;
         else if (phase_in == alpnp_pkg::PH_TEXT)
            result.status = alpnp_pkg::ST_TRUNCATED;
         else if (server_side && (names_seen_in != alpnp_pkg::NAME_CNT_W'(1)))
            result.status = alpnp_pkg::ST_SERVER_COUNT;
         else
            result.status = alpnp_pkg::ST_OK;
      end
   end

   // state update; a closing byte returns to the header phase
   always_ff @(posedge clock) begin
      if (reset || (advance && word.last_byte)) begin
         phase_ff              <= alpnp_pkg::PH_HDR_HI;
         declared_length_ff    <= '0;
         bytes_after_header_ff <= '0;
         name_bytes_left_ff    <= '0;
         names_seen_ff         <= '0;
         empty_name_seen_ff    <= 1'b0;
         first_pending_ff      <= 1'b0;
      end else if (advance) begin
         phase_ff              <= phase_in;
         declared_length_ff    <= declared_length_in;
         bytes_after_header_ff <= bytes_after_header_in;
         name_bytes_left_ff    <= name_bytes_left_in;
         names_seen_ff         <= names_seen_in;
         empty_name_seen_ff    <= empty_name_seen_in;
         first_pending_ff      <= first_pending_in;
      end
   end

endmodule

/* rtl/alpnp_out_stage.sv */
// ----------------------------------------------------------------------------
// alpnp_out_stage
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module alpnp_out_stage (
   input  logic                    clock,
   input  logic                    reset,
   alpnp_rsp_if.source             rsp_ch,
   input  logic                    load,
   input  alpnp_pkg::rsp_word_type result,
   output logic                    can_load
);

   logic                     valid_ff;
   logic                     valid_in;
   alpnp_pkg::rsp_word_type  word_ff;

   assign can_load = !valid_ff || rsp_ch.ready;
   assign valid_in = load ? 1'b1 : (valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= result;
      end
   end

   // drive the channel from the held word
   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.byte_out    = word_ff.byte_out;
   assign rsp_ch.in_name     = word_ff.in_name;
   assign rsp_ch.name_first  = word_ff.name_first;
   assign rsp_ch.name_last   = word_ff.name_last;
   assign rsp_ch.name_number = word_ff.name_number;
   assign rsp_ch.frame_end   = word_ff.frame_end;
   assign rsp_ch.status      = word_ff.status;
   assign rsp_ch.name_total  = word_ff.name_total;

endmodule

/* tb/tb_alpn_extension_parser.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_alpn_extension_parser
// Self-checking bench for the ALPN extension body parser. A short table of
// hand-picked frames comes first. Random frames follow, mostly well formed
// and partly broken, under both settings of server_side. Every result word
// is checked field by field against an in-bench model of the parse (pinned
// rows supply status and name_total), with random idle gaps on both channels.
// ----------------------------------------------------------------------------
module tb_alpn_extension_parser;

   localparam int unsigned RANDOM_ITEMS = 640;
   localparam int unsigned PHASES       = 4;
   localparam int unsigned HOLD_CYCLES  = 64;
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam int unsigned CYCLE_LIMIT  = 2_000_000;

   localparam logic [alpnp_pkg::BYTE_CNT_W-1:0] BYTES_SAT = '1;
   localparam logic [alpnp_pkg::NAME_CNT_W-1:0] NAMES_SAT = '1;

   // one row of the directed table; pinned rows carry a typed-in status/total
   typedef struct {
      bit                               srv;
      logic [7:0]                       data;
      bit                               lst;
      bit                               pin;
      alpnp_pkg::status_type            st;
      logic [alpnp_pkg::NAME_CNT_W-1:0] tot;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;

   alpnp_req_if req_ch ();
   alpnp_rsp_if rsp_ch ();
   alpnp_csr_if csr_ch ();

   alpn_extension_parser i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // parse state mirror
   bit                               side_cfg;
   alpnp_pkg::phase_type             prs_phase;
   logic [alpnp_pkg::LIST_LEN_W-1:0] prs_decl_len;
   logic [alpnp_pkg::BYTE_CNT_W-1:0] prs_body_cnt;
   logic [7:0]                       prs_text_left;
   logic [alpnp_pkg::NAME_CNT_W-1:0] prs_names;
   bit                               prs_empty_seen;
   bit                               prs_first_pending;

   alpnp_pkg::rsp_word_type owed_words [$];
   int unsigned             hold_requests;
   int unsigned             items_sent;
   int unsigned             mismatch_count;
   int unsigned             cycle_count;

   dir_row_type directed_rows [25] = '{
      // short header right after reset
      '{1'b0, 8'h00, 1'b1, 1'b1, alpnp_pkg::ST_SHORT_HDR,    15'd0},
      // empty list, client: ok (server_side resets to 0)
      '{1'b0, 8'h00, 1'b0, 1'b0, alpnp_pkg::ST_OK,           15'd0},
      '{1'b0, 8'h00, 1'b1, 1'b1, alpnp_pkg::ST_OK,           15'd0},
      // two one-byte names, extreme text values
      '{1'b0, 8'h00, 1'b0, 1'b0, alpnp_pkg::ST_OK,           15'd0},
      '{1'b0, 8'h04, 1'b0, 1'b0, alpnp_pkg::ST_OK,           15'd0},
      '{1'b0, 8'h01, 1'b0, 1'b0, alpnp_pkg::ST_OK,           15'd0},
      '{1'b0, 8'hFF, 1'b0, 1'b0, alpnp_pkg::ST_OK,           15'd0},
      '{1'b0, 8'h01, 1'b0, 1'b0, alpnp_pkg::ST_OK,           15'd0},
      '{1'b0, 8'h80, 1'b1, 1'b1, alpnp_pkg::ST_OK,           15'd2},
      // two empty names
      '{1'b0, 8'h00, 1'b0, 1'b0, alpnp_pkg::ST_OK,           15'd0},
      '{1'b0, 8'h02, 1'b0, 1'b0, alpnp_pkg::ST_OK,           15'd0},
      '{1'b0, 8'h00, 1'b0, 1'b0, alpnp_pkg::ST_OK,           15'd0},
      '{1'b0, 8'h00, 1'b1, 1'b1, alpnp_pkg::ST_EMPTY_NAME,   15'd0},
      // name cut short
      '{1'b0, 8'h00, 1'b0, 1'b0, alpnp_pkg::ST_OK,           15'd0},
      '{1'b0, 8'h02, 1'b0, 1'b0, alpnp_pkg::ST_OK,           15'd0},
      '{1'b0, 8'h05, 1'b0, 1'b0, alpnp_pkg::ST_OK,           15'd0},
      '{1'b0, 8'h41, 1'b1, 1'b1, alpnp_pkg::ST_TRUNCATED,    15'd0},
      // header closes the frame: not short, but length is off
      '{1'b0, 8'hFF, 1'b0, 1'b0, alpnp_pkg::ST_OK,           15'd0},
      '{1'b0, 8'hFF, 1'b1, 1'b1, alpnp_pkg::ST_LEN_MISMATCH, 15'd0},
      // server with one name
      '{1'b1, 8'h00, 1'b0, 1'b0, alpnp_pkg::ST_OK,           15'd0},
      '{1'b1, 8'h02, 1'b0, 1'b0, alpnp_pkg::ST_OK,           15'd0},
      '{1'b1, 8'h01, 1'b0, 1'b0, alpnp_pkg::ST_OK,           15'd0},
      '{1'b1, 8'h7F, 1'b1, 1'b1, alpnp_pkg::ST_OK,           15'd1},
      // server with no name
      '{1'b1, 8'h00, 1'b0, 1'b0, alpnp_pkg::ST_OK,           15'd0},
      '{1'b1, 8'h00, 1'b1, 1'b1, alpnp_pkg::ST_SERVER_COUNT, 15'd0}
   };

   // mostly no gap, some short ones, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int unsigned pick_name_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(1, 8);
      if (r < 97) return $urandom_range(9, 40);
      return ($urandom_range(0, 1) == 1) ? 255 : $urandom_range(200, 254);
   endfunction

   task automatic clear_parse();
      prs_phase         = alpnp_pkg::PH_HDR_HI;
      prs_decl_len      = '0;
      prs_body_cnt      = '0;
      prs_text_left     = '0;
      prs_names         = '0;
      prs_empty_seen    = 1'b0;
      prs_first_pending = 1'b0;
   endtask

   // advance the parse by one byte and build the result word it yields
   task automatic parse_byte(input logic [7:0] b, input logic lst,
                             output alpnp_pkg::rsp_word_type w);
      alpnp_pkg::phase_type start_phase;
      start_phase   = prs_phase;
      w             = '0;
      w.byte_out    = b;
      w.name_number = prs_names;
      w.frame_end   = lst;
      w.status      = alpnp_pkg::ST_OK;
      unique case (prs_phase)
         alpnp_pkg::PH_HDR_HI: begin
            prs_decl_len = {b, 8'h00};
            prs_phase    = alpnp_pkg::PH_HDR_LO;
         end
         alpnp_pkg::PH_HDR_LO: begin
            prs_decl_len[7:0] = b;
            prs_phase         = alpnp_pkg::PH_LEN;
         end
         alpnp_pkg::PH_LEN: begin
            if (prs_body_cnt != BYTES_SAT) prs_body_cnt++;
            if (b == 8'h00) begin
               prs_empty_seen = 1'b1;
            end else begin
               prs_text_left     = b;
               prs_first_pending = 1'b1;
               prs_phase         = alpnp_pkg::PH_TEXT;
            end
         end
         alpnp_pkg::PH_TEXT: begin
            if (prs_body_cnt != BYTES_SAT) prs_body_cnt++;
            w.in_name         = 1'b1;
            w.name_first      = prs_first_pending;
            prs_first_pending = 1'b0;
            prs_text_left     = prs_text_left - 8'd1;
            if (prs_text_left == 8'd0) begin
               w.name_last = 1'b1;
               if (prs_names != NAMES_SAT) prs_names++;
               prs_phase = alpnp_pkg::PH_LEN;
            end
         end
      endcase
      // closing word: status by priority, then back to the header phase
      if (lst) begin
         w.name_total = prs_names;
         priority if (start_phase == alpnp_pkg::PH_HDR_HI)
            w.status = alpnp_pkg::ST_SHORT_HDR;
         else if ({1'b0, prs_decl_len} != prs_body_cnt)
            w.status = alpnp_pkg::ST_LEN_MISMATCH;
         else if (prs_empty_seen)
            w.status = alpnp_pkg::ST_EMPTY_NAME;
         else if (prs_phase == alpnp_pkg::PH_TEXT)
            w.status = alpnp_pkg::ST_TRUNCATED;
         else if (side_cfg && prs_names != 15'd1)
            w.status = alpnp_pkg::ST_SERVER_COUNT;
         else
            w.status = alpnp_pkg::ST_OK;
         clear_parse();
      end
   endtask

   function automatic void check_field(input string fname, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         $error("%s: expected %0d, actual %0d", fname, want, got);
      end
   endfunction

   function automatic void check_word();
      alpnp_pkg::rsp_word_type want;
      if (owed_words.size() == 0) begin
         mismatch_count++;
         $error("unexpected word, byte_out %0d", rsp_ch.byte_out);
      end else begin
         want = owed_words.pop_front();
         check_field("byte_out",    want.byte_out,    rsp_ch.byte_out);
         check_field("in_name",     want.in_name,     rsp_ch.in_name);
         check_field("name_first",  want.name_first,  rsp_ch.name_first);
         check_field("name_last",   want.name_last,   rsp_ch.name_last);
         check_field("name_number", want.name_number, rsp_ch.name_number);
         check_field("frame_end",   want.frame_end,   rsp_ch.frame_end);
         check_field("status",      want.status,      rsp_ch.status);
         check_field("name_total",  want.name_total,  rsp_ch.name_total);
      end
   endfunction

   // offer one word, log its expected result once taken, then maybe idle
   task automatic send_byte(input logic [7:0] b, input logic lst, input bit pin,
                            input alpnp_pkg::status_type pin_st,
                            input logic [alpnp_pkg::NAME_CNT_W-1:0] pin_tot);
      alpnp_pkg::rsp_word_type w;
      int unsigned             gap;
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last_byte <= lst;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      parse_byte(b, lst, w);
      if (pin) begin
         w.status     = pin_st;
         w.name_total = pin_tot;
      end
      owed_words = {owed_words, w};
      items_sent++;
      gap = pick_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering and let every owed word come back
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (owed_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_side(input bit v);
      csr_ch.valid       <= 1'b1;
      csr_ch.server_side <= v;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      side_cfg = v;
      csr_ch.valid <= 1'b0;
   endtask

   // one random frame: well formed most of the time, else broken or noise
   task automatic send_random_frame();
      logic [7:0]  frame [$];
      logic [15:0] declared;
      int unsigned kind, n_names, len, cut, r;
      frame = {};
      len   = 0;
      kind  = $urandom_range(0, 99);
      if (kind < 87) begin
         if (side_cfg && $urandom_range(0, 9) < 7) n_names = 1;
         else n_names = $urandom_range(0, 4);
         if (kind >= 80 && n_names == 0) n_names = 1;
         repeat (n_names) begin
            len = pick_name_len();
            frame = {frame, 8'(len)};
            repeat (len) frame = {frame, 8'($urandom)};
         end
         // zero-length name, at the front or the back of the list
         if (kind >= 73 && kind < 80) begin
            if ($urandom_range(0, 1) == 1) frame.push_front(8'h00);
            else frame = {frame, 8'h00};
         end
         // drop part of the last name's text, length kept consistent
         if (kind >= 80) begin
            cut = $urandom_range(1, len);
            repeat (cut) void'(frame.pop_back());
         end
         declared = 16'(frame.size());
         if (kind >= 65 && kind < 73) begin
            r = $urandom_range(0, 2);
            if (r == 0)      declared = declared + 16'($urandom_range(1, 3));
            else if (r == 1) declared = declared - 16'($urandom_range(1, 3));
            else             declared = 16'($urandom);
         end
         frame.push_front(declared[7:0]);
         frame.push_front(declared[15:8]);
      end else if (kind < 92) begin
         frame = {frame, 8'($urandom)};
      end else if (kind < 96) begin
         frame = {frame, 8'($urandom)};
         frame = {frame, 8'($urandom)};
      end else begin
         repeat ($urandom_range(2, 22)) frame = {frame, 8'($urandom)};
      end
      foreach (frame[i])
         send_byte(frame[i], i == frame.size() - 1, 1'b0, alpnp_pkg::ST_OK, '0);
   endtask

   // result side: check each taken word, stall at random, hold off on request
   initial begin
      int unsigned stall_left;
      int unsigned hold_left;
      int unsigned holds_done;
      stall_left   = 0;
      hold_left    = 0;
      holds_done   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) check_word();
         if (holds_done != hold_requests) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // run limit: random frames at worst-case gaps on both sides, several times over
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_alpn_extension_parser failed");
      $finish;
   end

   initial begin
      int unsigned phase_start;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.data_byte   = '0;
      req_ch.last_byte   = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.server_side = 1'b0;
      side_cfg           = 1'b0;
      hold_requests      = 0;
      items_sent         = 0;
      mismatch_count     = 0;
      clear_parse();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table, server_side switched where the table asks
      foreach (directed_rows[i]) begin
         if (directed_rows[i].srv != side_cfg) begin
            wait_idle();
            write_side(directed_rows[i].srv);
         end
         send_byte(directed_rows[i].data, directed_rows[i].lst, directed_rows[i].pin,
                   directed_rows[i].st, directed_rows[i].tot);
      end

      // random frames in phases, each under its own server_side setting
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         write_side(p == 1 || (p > 1 && $urandom_range(0, 1) == 1));
         if (p % 2 == 1) hold_requests++;
         phase_start = items_sent;
         while (items_sent - phase_start < RANDOM_ITEMS / PHASES) send_random_frame();
      end

      wait_idle();
      if (mismatch_count == 0 && owed_words.size() == 0)
         $display("tb_alpn_extension_parser passed");
      else
         $display("tb_alpn_extension_parser failed");
      $finish;
   end

endmodule

/* sim.f */
rtl/alpnp_pkg.sv
rtl/alpnp_ifs.sv
rtl/alpnp_in_stage.sv
rtl/alpnp_parser.sv
rtl/alpnp_out_stage.sv
rtl/alpn_extension_parser.sv
tb/tb_alpn_extension_parser.sv
